>>> src/rsi_pkg.sv
// Shared types and constants for the ray-sphere intersection core.
package rsi_pkg;

    localparam int RSI_QDEPTH  = 4;
    localparam int RSI_MUL_LAT = 5;
    localparam int RSI_DISC_W  = 126;

    localparam logic [30:0] RSI_T_MAX = 31'h7fffffff;
    localparam logic [16:0] RSI_ONE   = 17'h10000;

    typedef enum logic [2:0] {
        RSI_REG_CENTER_X = 3'd0,
        RSI_REG_CENTER_Y = 3'd1,
        RSI_REG_CENTER_Z = 3'd2,
        RSI_REG_RADIUS   = 3'd3,
        RSI_REG_ID       = 3'd4
    } rsi_reg_e;

    typedef struct packed {
        logic [2:0][31:0] center;
        logic [30:0]      radius;
        logic [15:0]      id;
    } rsi_cfg_t;

    // classified ray, front to back
    typedef struct packed {
        logic                  miss;
        logic [RSI_DISC_W-1:0] disc;
        logic [65:0]           b;
        logic [64:0]           a;
        logic [2:0][31:0]      o;
        logic [2:0][31:0]      d;
    } rsi_ray_t;

endpackage

>>> src/ray_sphere_intersect_core.sv
// Top level: register port, front pipeline, queue and back pipeline.
//
//   channel   handshake                  word
//   ray       ray_valid / ray_stall      ray_origin_x..z, ray_dir_x..z
//   result    result_valid / result_stall hit, hit_distance, point_*, normal_*,
//                                          object_id
//   config    psel/penable/pwrite/pready paddr, pwdata, prdata
//
// One ray per cycle sustained while nothing stalls. The front uses two
// five-stage wide multipliers for the discriminant; the back holds the
// 79-step square root, 31-step divide and 17-step normal divide.
// Reset clears all valid state and loads the default sphere (unit radius).
// The front stalls only when the queue is full; the back stalls only while a
// result word is held by result_stall.
module ray_sphere_intersect_core import rsi_pkg::*; #(
    parameter int QDEPTH = RSI_QDEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               ray_valid,
    output logic               ray_stall,
    input  logic signed [31:0] ray_origin_x,
    input  logic signed [31:0] ray_origin_y,
    input  logic signed [31:0] ray_origin_z,
    input  logic signed [31:0] ray_dir_x,
    input  logic signed [31:0] ray_dir_y,
    input  logic signed [31:0] ray_dir_z,
    output logic               result_valid,
    input  logic               result_stall,
    output logic               hit,
    output logic [30:0]        hit_distance,
    output logic signed [31:0] point_x,
    output logic signed [31:0] point_y,
    output logic signed [31:0] point_z,
    output logic signed [17:0] normal_x,
    output logic signed [17:0] normal_y,
    output logic signed [17:0] normal_z,
    output logic [15:0]        object_id
);
    logic [31:0] center_x_reg, center_y_reg, center_z_reg;
    logic [30:0] radius_reg;
    logic [15:0] sphere_id_reg;
    rsi_reg_e    reg_idx;
    logic        wr_en;
    rsi_cfg_t    cfg;
    logic        push, pop, full, empty;
    rsi_ray_t    push_word, pop_word;

    assign pready  = 1'b1;
    assign reg_idx = rsi_reg_e'(paddr[4:2]);
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg  <= '0;
            center_y_reg  <= '0;
            center_z_reg  <= '0;
            radius_reg    <= 31'h00010000;
            sphere_id_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                RSI_REG_CENTER_X: center_x_reg  <= pwdata;
                RSI_REG_CENTER_Y: center_y_reg  <= pwdata;
                RSI_REG_CENTER_Z: center_z_reg  <= pwdata;
                RSI_REG_RADIUS:   radius_reg    <= pwdata[30:0];
                RSI_REG_ID:       sphere_id_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            RSI_REG_CENTER_X: prdata = center_x_reg;
            RSI_REG_CENTER_Y: prdata = center_y_reg;
            RSI_REG_CENTER_Z: prdata = center_z_reg;
            RSI_REG_RADIUS:   prdata = 32'(radius_reg);
            RSI_REG_ID:       prdata = 32'(sphere_id_reg);
            default:          prdata = '0;
        endcase
    end

    assign cfg.center = {center_z_reg, center_y_reg, center_x_reg};
    assign cfg.radius = radius_reg;
    assign cfg.id     = sphere_id_reg;

    rsi_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .ray_valid    (ray_valid),
        .ray_stall    (ray_stall),
        .ray_origin_x (ray_origin_x),
        .ray_origin_y (ray_origin_y),
        .ray_origin_z (ray_origin_z),
        .ray_dir_x    (ray_dir_x),
        .ray_dir_y    (ray_dir_y),
        .ray_dir_z    (ray_dir_z),
        .push         (push),
        .push_word    (push_word),
        .full         (full)
    );

    rsi_fifo #(.DEPTH(QDEPTH)) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (push_word),
        .full  (full),
        .pop   (pop),
        .rdata (pop_word),
        .empty (empty)
    );

    rsi_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .pop          (pop),
        .pop_word     (pop_word),
        .empty        (empty),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .hit          (hit),
        .hit_distance (hit_distance),
        .point_x      (point_x),
        .point_y      (point_y),
        .point_z      (point_z),
        .normal_x     (normal_x),
        .normal_y     (normal_y),
        .normal_z     (normal_z),
        .object_id    (object_id)
    );

endmodule

>>> src/rsi_mul.sv
// Pipelined wide signed multiplier built from narrow partial products.
module rsi_mul #(
    parameter int AW = 32,
    parameter int BW = 32
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [AW-1:0] a,
    input  logic signed [BW-1:0] b,
    output logic signed [AW+BW-1:0] p
);
    localparam int NC = 3;
    localparam int CA = (AW + NC - 1) / NC;
    localparam int CB = (BW + NC - 1) / NC;
    localparam int RW = CA + NC * CB;
    localparam int MW = NC * (CA + CB);

    logic [AW-1:0]          abs_a;
    logic [BW-1:0]          abs_b;
    logic [NC*CA-1:0]       ma_reg;
    logic [NC*CB-1:0]       mb_reg;
    logic [3:0]             neg_reg;
    logic [CA+CB-1:0]       pp_reg [NC][NC];
    logic [RW-1:0]          row_reg [NC];
    logic [RW-1:0]          row_next [NC];
    logic [MW-1:0]          mag_reg;
    logic [MW-1:0]          mag_next;
    logic signed [AW+BW-1:0] p_reg;

    assign abs_a = a[AW-1] ? AW'(-a) : AW'(a);
    assign abs_b = b[BW-1] ? BW'(-b) : BW'(b);

    always_comb
    begin
        for (int i = 0; i < NC; i++)
        begin
            row_next[i] = '0;
            for (int j = 0; j < NC; j++)
            begin
                row_next[i] = row_next[i] + (RW'(pp_reg[i][j]) << (j * CB));
            end
        end
        mag_next = '0;
        for (int i = 0; i < NC; i++)
        begin
            mag_next = mag_next + (MW'(row_reg[i]) << (i * CA));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ma_reg  <= (NC*CA)'(abs_a);
            mb_reg  <= (NC*CB)'(abs_b);
            neg_reg <= {neg_reg[2:0], a[AW-1] ^ b[BW-1]};
            for (int i = 0; i < NC; i++)
            begin
                for (int j = 0; j < NC; j++)
                begin
                    pp_reg[i][j] <= (CA+CB)'(ma_reg[i*CA +: CA]) *
                                    (CA+CB)'(mb_reg[j*CB +: CB]);
                end
            end
            row_reg <= row_next;
            mag_reg <= mag_next;
            p_reg   <= neg_reg[3] ? -(AW+BW)'(mag_reg) : (AW+BW)'(mag_reg);
        end
    end

    assign p = p_reg;

endmodule

>>> src/rsi_front.sv
// Front pipeline: dot products, discriminant and miss classification.
module rsi_front import rsi_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  rsi_cfg_t           cfg,
    input  logic               ray_valid,
    output logic               ray_stall,
    input  logic signed [31:0] ray_origin_x,
    input  logic signed [31:0] ray_origin_y,
    input  logic signed [31:0] ray_origin_z,
    input  logic signed [31:0] ray_dir_x,
    input  logic signed [31:0] ray_dir_y,
    input  logic signed [31:0] ray_dir_z,
    output logic               push,
    output rsi_ray_t           push_word,
    input  logic               full
);
    localparam int NS = 4 + RSI_MUL_LAT;

    typedef struct packed {
        logic             azero;
        logic [64:0]      a;
        logic [65:0]      b;
        logic [2:0][31:0] o;
        logic [2:0][31:0] d;
    } dly_t;

    logic [NS-1:0]       vld_reg;
    logic                en;
    logic signed [32:0]  p0_reg [3];
    logic [2:0][31:0]    o0_reg, d0_reg, o1_reg, d1_reg, o2_reg, d2_reg;
    logic signed [63:0]  dd1_reg [3];
    logic signed [64:0]  dp1_reg [3];
    logic signed [65:0]  pp1_reg [3];
    logic [61:0]         rr1_reg;
    logic signed [65:0]  a2_reg, b2_reg;
    logic signed [66:0]  k2_reg;
    logic signed [131:0] bb;
    logic signed [132:0] ak;
    logic signed [133:0] disc;
    dly_t                dl_reg [RSI_MUL_LAT];
    rsi_ray_t            out_reg;

    assign en        = !(vld_reg[NS-1] && full);
    assign ray_stall = !en;
    assign push      = en && vld_reg[NS-1];
    assign push_word = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NS-2:0], ray_valid};
        end
    end

    rsi_mul #(.AW(66), .BW(66)) u_mul_bb (
        .clk (clk),
        .en  (en),
        .a   (b2_reg),
        .b   (b2_reg),
        .p   (bb)
    );

    rsi_mul #(.AW(66), .BW(67)) u_mul_ak (
        .clk (clk),
        .en  (en),
        .a   (a2_reg),
        .b   (k2_reg),
        .p   (ak)
    );

    assign disc = 134'(bb) - 134'(ak);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p0_reg[0] <= 33'(ray_origin_x) - 33'($signed(cfg.center[0]));
            p0_reg[1] <= 33'(ray_origin_y) - 33'($signed(cfg.center[1]));
            p0_reg[2] <= 33'(ray_origin_z) - 33'($signed(cfg.center[2]));
            o0_reg    <= {ray_origin_z, ray_origin_y, ray_origin_x};
            d0_reg    <= {ray_dir_z, ray_dir_y, ray_dir_x};

            for (int i = 0; i < 3; i++)
            begin
                dd1_reg[i] <= $signed(d0_reg[i]) * $signed(d0_reg[i]);
                dp1_reg[i] <= 65'($signed(d0_reg[i])) * 65'(p0_reg[i]);
                pp1_reg[i] <= 66'(p0_reg[i]) * 66'(p0_reg[i]);
            end
            rr1_reg <= 62'(cfg.radius) * 62'(cfg.radius);
            o1_reg  <= o0_reg;
            d1_reg  <= d0_reg;

            a2_reg <= 66'(dd1_reg[0]) + 66'(dd1_reg[1]) + 66'(dd1_reg[2]);
            b2_reg <= 66'(dp1_reg[0]) + 66'(dp1_reg[1]) + 66'(dp1_reg[2]);
            k2_reg <= 67'(pp1_reg[0]) + 67'(pp1_reg[1]) + 67'(pp1_reg[2]) - 67'(rr1_reg);
            o2_reg <= o1_reg;
            d2_reg <= d1_reg;

            dl_reg[0].azero <= (a2_reg == '0);
            dl_reg[0].a     <= a2_reg[64:0];
            dl_reg[0].b     <= b2_reg;
            dl_reg[0].o     <= o2_reg;
            dl_reg[0].d     <= d2_reg;
            for (int i = 1; i < RSI_MUL_LAT; i++)
            begin
                dl_reg[i] <= dl_reg[i-1];
            end

            out_reg.miss <= dl_reg[RSI_MUL_LAT-1].azero || disc[133];
            out_reg.disc <= disc[RSI_DISC_W-1:0];
            out_reg.b    <= dl_reg[RSI_MUL_LAT-1].b;
            out_reg.a    <= dl_reg[RSI_MUL_LAT-1].a;
            out_reg.o    <= dl_reg[RSI_MUL_LAT-1].o;
            out_reg.d    <= dl_reg[RSI_MUL_LAT-1].d;
        end
    end

endmodule

>>> src/rsi_fifo.sv
// Small queue of classified rays between front and back pipelines.
module rsi_fifo import rsi_pkg::*; #(
    parameter int DEPTH = RSI_QDEPTH
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  rsi_ray_t wdata,
    output logic     full,
    input  logic     pop,
    output rsi_ray_t rdata,
    output logic     empty
);
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    rsi_ray_t        mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]   cnt_reg;

    assign full  = (cnt_reg == CW'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign rdata = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

>>> src/rsi_back.sv
// Back pipeline: square root, root choice, divide, hit point and normal.
module rsi_back import rsi_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  rsi_cfg_t           cfg,
    output logic               pop,
    input  rsi_ray_t           pop_word,
    input  logic               empty,
    output logic               result_valid,
    input  logic               result_stall,
    output logic               hit,
    output logic [30:0]        hit_distance,
    output logic signed [31:0] point_x,
    output logic signed [31:0] point_y,
    output logic signed [31:0] point_z,
    output logic signed [17:0] normal_x,
    output logic signed [17:0] normal_y,
    output logic signed [17:0] normal_z,
    output logic [15:0]        object_id
);
    localparam int SQ_N  = (RSI_DISC_W + 32) / 2;
    localparam int DIV_N = 31;
    localparam int NRM_N = 17;
    localparam int NB    = SQ_N + DIV_N + NRM_N + 7;

    typedef struct packed {
        logic             miss;
        logic [64:0]      a;
        logic [65:0]      b;
        logic [2:0][31:0] o;
        logic [2:0][31:0] d;
    } bpl_t;

    typedef struct packed {
        logic [2*SQ_N-1:0] n;
        logic [SQ_N+1:0]   rem;
        logic [SQ_N-1:0]   root;
        bpl_t              pl;
    } sq_t;

    typedef struct packed {
        logic        sat;
        logic [95:0] rem;
        logic [30:0] q;
        bpl_t        pl;
    } dv_t;

    typedef struct packed {
        logic             miss;
        logic [30:0]      t;
        logic [2:0][31:0] pt;
        logic [2:0]       neg;
        logic [2:0]       ovf;
        logic [2:0][48:0] rem;
        logic [2:0][16:0] m;
    } nr_t;

    logic [NB-1:0]       vld_reg;
    logic                en;
    sq_t                 sq_reg  [SQ_N+1];
    sq_t                 sq_next [SQ_N];
    logic [SQ_N+1:0]     sq_r2 [SQ_N];
    logic [SQ_N+1:0]     sq_tr [SQ_N];
    logic signed [83:0]  mb, nn_near, nn_far;
    dv_t                 nm_reg;
    dv_t                 nm_next;
    dv_t                 dv0_next;
    dv_t                 dv_reg  [DIV_N+1];
    dv_t                 dv_next [DIV_N];
    logic [95:0]         dv_sh   [DIV_N];
    logic [30:0]         t_sel;
    logic signed [31:0]  t_s;
    logic [30:0]         pm_t_reg;
    logic signed [63:0]  pm_dt_reg [3];
    bpl_t                pm_pl_reg;
    logic signed [48:0]  pa_sum [3];
    logic [30:0]         pa_t_reg;
    logic [2:0][31:0]    pa_pt_reg;
    logic                pa_miss_reg;
    logic signed [32:0]  ns_qv [3];
    logic [32:0]         ns_mag [3];
    logic [48:0]         ns_nn [3];
    nr_t                 nr_reg  [NRM_N+1];
    nr_t                 nr_next [NRM_N];
    logic [48:0]         nr_sh   [NRM_N];
    logic [16:0]         m_fin [3];
    logic signed [17:0]  n_fin [3];

    logic                hit_reg;
    logic [30:0]         dist_reg;
    logic [2:0][31:0]    pt_reg;
    logic signed [17:0]  nrm_reg [3];
    logic [15:0]         id_reg;

    assign en           = !(vld_reg[NB-1] && result_stall);
    assign pop          = en && !empty;
    assign result_valid = vld_reg[NB-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NB-2:0], pop};
        end
    end

    // square root, one result bit per stage
    always_comb
    begin
        for (int j = 0; j < SQ_N; j++)
        begin
            sq_r2[j]   = {sq_reg[j].rem[SQ_N-1:0], sq_reg[j].n[2*SQ_N-1 -: 2]};
            sq_tr[j]   = {sq_reg[j].root, 2'b01};
            sq_next[j] = sq_reg[j];
            sq_next[j].n = sq_reg[j].n << 2;
            if (sq_r2[j] >= sq_tr[j])
            begin
                sq_next[j].rem  = sq_r2[j] - sq_tr[j];
                sq_next[j].root = {sq_reg[j].root[SQ_N-2:0], 1'b1};
            end
            else
            begin
                sq_next[j].rem  = sq_r2[j];
                sq_next[j].root = {sq_reg[j].root[SQ_N-2:0], 1'b0};
            end
        end
    end

    // root choice
    always_comb
    begin
        mb      = -(84'($signed(sq_reg[SQ_N].pl.b)) <<< 16);
        nn_near = mb - 84'(sq_reg[SQ_N].root);
        nn_far  = mb + 84'(sq_reg[SQ_N].root);

        nm_next.sat = 1'b0;
        nm_next.q   = '0;
        nm_next.pl  = sq_reg[SQ_N].pl;
        if (!nn_near[83])
        begin
            nm_next.rem = 96'(nn_near[82:0]);
        end
        else
        begin
            nm_next.rem = 96'(nn_far[82:0]);
            if (nn_far[83])
            begin
                nm_next.pl.miss = 1'b1;
            end
        end

        dv0_next     = nm_reg;
        dv0_next.sat = nm_reg.rem >= {nm_reg.pl.a, 31'b0};
    end

    // restoring divide, one quotient bit per stage
    always_comb
    begin
        for (int i = 0; i < DIV_N; i++)
        begin
            dv_sh[i]   = 96'(dv_reg[i].pl.a) << (DIV_N - 1 - i);
            dv_next[i] = dv_reg[i];
            if (!dv_reg[i].sat && dv_reg[i].rem >= dv_sh[i])
            begin
                dv_next[i].rem = dv_reg[i].rem - dv_sh[i];
                dv_next[i].q   = {dv_reg[i].q[DIV_N-2:0], 1'b1};
            end
            else
            begin
                dv_next[i].q   = {dv_reg[i].q[DIV_N-2:0], 1'b0};
            end
        end
    end

    assign t_sel = dv_reg[DIV_N].sat ? RSI_T_MAX : dv_reg[DIV_N].q;
    assign t_s   = {1'b0, t_sel};

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            pa_sum[i] = 49'($signed(pm_pl_reg.o[i])) + 49'(pm_dt_reg[i] >>> 16);
            ns_qv[i]  = 33'($signed(pa_pt_reg[i])) - 33'($signed(cfg.center[i]));
            ns_mag[i] = ns_qv[i][32] ? 33'(-ns_qv[i]) : 33'(ns_qv[i]);
            ns_nn[i]  = 49'({ns_mag[i][31:0], 16'b0}) + 49'(cfg.radius[30:1]);
        end
    end

    // normal divide, three lanes
    always_comb
    begin
        for (int k = 0; k < NRM_N; k++)
        begin
            nr_sh[k]   = 49'(cfg.radius) << (NRM_N - 1 - k);
            nr_next[k] = nr_reg[k];
            for (int i = 0; i < 3; i++)
            begin
                if (!nr_reg[k].ovf[i] && nr_reg[k].rem[i] >= nr_sh[k])
                begin
                    nr_next[k].rem[i] = nr_reg[k].rem[i] - nr_sh[k];
                    nr_next[k].m[i]   = {nr_reg[k].m[i][NRM_N-2:0], 1'b1};
                end
                else
                begin
                    nr_next[k].m[i]   = {nr_reg[k].m[i][NRM_N-2:0], 1'b0};
                end
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (cfg.radius == '0)
            begin
                m_fin[i] = '0;
            end
            else if (nr_reg[NRM_N].ovf[i] || nr_reg[NRM_N].m[i] > RSI_ONE)
            begin
                m_fin[i] = RSI_ONE;
            end
            else
            begin
                m_fin[i] = nr_reg[NRM_N].m[i];
            end
            n_fin[i] = nr_reg[NRM_N].neg[i] ? -18'(m_fin[i]) : 18'(m_fin[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_reg[0].n       <= {pop_word.disc, 32'b0};
            sq_reg[0].rem     <= '0;
            sq_reg[0].root    <= '0;
            sq_reg[0].pl.miss <= pop_word.miss;
            sq_reg[0].pl.a    <= pop_word.a;
            sq_reg[0].pl.b    <= pop_word.b;
            sq_reg[0].pl.o    <= pop_word.o;
            sq_reg[0].pl.d    <= pop_word.d;
            for (int j = 0; j < SQ_N; j++)
            begin
                sq_reg[j+1] <= sq_next[j];
            end

            nm_reg <= nm_next;

            dv_reg[0] <= dv0_next;
            for (int i = 0; i < DIV_N; i++)
            begin
                dv_reg[i+1] <= dv_next[i];
            end

            pm_t_reg  <= t_sel;
            pm_pl_reg <= dv_reg[DIV_N].pl;
            for (int i = 0; i < 3; i++)
            begin
                pm_dt_reg[i] <= $signed(dv_reg[DIV_N].pl.d[i]) * t_s;
            end

            pa_t_reg    <= pm_t_reg;
            pa_miss_reg <= pm_pl_reg.miss;
            for (int i = 0; i < 3; i++)
            begin
                if (pa_sum[i][48:31] != {18{pa_sum[i][48]}})
                begin
                    pa_pt_reg[i] <= pa_sum[i][48] ? 32'h80000000 : 32'h7fffffff;
                end
                else
                begin
                    pa_pt_reg[i] <= pa_sum[i][31:0];
                end
            end

            nr_reg[0].miss <= pa_miss_reg;
            nr_reg[0].t    <= pa_t_reg;
            nr_reg[0].pt   <= pa_pt_reg;
            for (int i = 0; i < 3; i++)
            begin
                nr_reg[0].neg[i] <= ns_qv[i][32];
                nr_reg[0].ovf[i] <= ns_nn[i] >= 49'({cfg.radius, 17'b0});
                nr_reg[0].rem[i] <= ns_nn[i];
                nr_reg[0].m[i]   <= '0;
            end
            for (int k = 0; k < NRM_N; k++)
            begin
                nr_reg[k+1] <= nr_next[k];
            end

            id_reg <= cfg.id;
            if (nr_reg[NRM_N].miss)
            begin
                hit_reg  <= 1'b0;
                dist_reg <= '0;
                pt_reg   <= '0;
                for (int i = 0; i < 3; i++)
                begin
                    nrm_reg[i] <= '0;
                end
            end
            else
            begin
                hit_reg  <= 1'b1;
                dist_reg <= nr_reg[NRM_N].t;
                pt_reg   <= nr_reg[NRM_N].pt;
                for (int i = 0; i < 3; i++)
                begin
                    nrm_reg[i] <= n_fin[i];
                end
            end
        end
    end

    assign hit          = hit_reg;
    assign hit_distance = dist_reg;
    assign point_x      = pt_reg[0];
    assign point_y      = pt_reg[1];
    assign point_z      = pt_reg[2];
    assign normal_x     = nrm_reg[0];
    assign normal_y     = nrm_reg[1];
    assign normal_z     = nrm_reg[2];
    assign object_id    = id_reg;

endmodule

>>> src/rsi_chk.sv
// Port-level checks on the result channel, bound to the top level.
module rsi_chk (
    input logic               clk,
    input logic               rst_n,
    input logic               result_valid,
    input logic               result_stall,
    input logic               hit,
    input logic [30:0]        hit_distance,
    input logic signed [31:0] point_x,
    input logic signed [31:0] point_y,
    input logic signed [31:0] point_z,
    input logic signed [17:0] normal_x,
    input logic signed [17:0] normal_y,
    input logic signed [17:0] normal_z
);
    a_rst_quiet: assert property (@(posedge clk) !rst_n |-> !result_valid)
        else $error("result word during reset");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(hit) &&
        $stable(hit_distance) && $stable(point_x))
        else $error("stalled result word changed");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !hit |-> hit_distance == '0 && point_x == '0 &&
        point_y == '0 && point_z == '0 && normal_x == '0 &&
        normal_y == '0 && normal_z == '0)
        else $error("miss word carries nonzero fields");

    a_norm_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && hit |-> normal_x <= 18'sd65536 && normal_x >= -18'sd65536 &&
        normal_y <= 18'sd65536 && normal_y >= -18'sd65536 &&
        normal_z <= 18'sd65536 && normal_z >= -18'sd65536)
        else $error("normal component out of range");

endmodule

bind ray_sphere_intersect_core rsi_chk u_chk (.*);

>>> bench/ray_sphere_intersect_core_tb.sv
// Testbench for the ray-sphere core: random and directed rays against a local predictor.
module ray_sphere_intersect_core_tb import rsi_pkg::*;;

    localparam int DRAIN_CYCLES = 160;
    localparam int STALL_LIMIT  = 20000;

    typedef struct packed {
        logic        hit;
        logic [30:0] tdist;
        logic [31:0] px, py, pz;
        logic [17:0] nx, ny, nz;
        logic [15:0] id;
    } hit_word_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               ray_valid = 1'b0;
    logic               ray_stall;
    logic signed [31:0] ray_origin_x = '0, ray_origin_y = '0, ray_origin_z = '0;
    logic signed [31:0] ray_dir_x = '0, ray_dir_y = '0, ray_dir_z = '0;
    logic               result_valid;
    logic               result_stall = 1'b1;
    logic               hit;
    logic [30:0]        hit_distance;
    logic signed [31:0] point_x, point_y, point_z;
    logic signed [17:0] normal_x, normal_y, normal_z;
    logic [15:0]        object_id;

    logic signed [31:0] sph_cx = '0, sph_cy = '0, sph_cz = '0;
    logic [30:0]        sph_r = 31'd65536;
    logic [15:0]        sph_id = '0;

    hit_word_t hits_pending[$];
    int        mismatches = 0;
    int        idle_free = 0;
    int        quiet_cnt = 0;

    ray_sphere_intersect_core u_dut (.*);

    always #5 clk = ~clk;

    always @(negedge clk)
        result_stall <= idle_free ? 1'b0 : ($urandom_range(99) < 23);

    function automatic logic [255:0] isqrt(input logic [255:0] n);
        logic [255:0] res, bt;
        res = '0;
        for (int i = 127; i >= 0; i--)
        begin
            bt = 256'd1 << (2 * i);
            if (n >= res + bt)
            begin
                n = n - (res + bt);
                res = (res >> 1) + bt;
            end
            else
            begin
                res = res >> 1;
            end
        end
        return res;
    endfunction

    function automatic hit_word_t trace_ray(input logic signed [31:0] o[3],
                                            input logic signed [31:0] d[3]);
        hit_word_t w;
        logic signed [255:0] a, b, k, p, dd, rr, disc, s, mb, num, q;
        logic signed [63:0] c[3], tt, pt, qv, mag, m;
        logic signed [63:0] cfg_r;
        logic [17:0] nv[3];
        logic [31:0] pv[3];
        w = '0;
        w.id = sph_id;
        c[0] = sph_cx; c[1] = sph_cy; c[2] = sph_cz;
        cfg_r = {33'd0, sph_r};
        a = 0; b = 0; k = 0;
        for (int i = 0; i < 3; i++)
        begin
            dd = d[i];
            p = 256'(o[i]) - 256'(c[i]);
            p = $signed(o[i]) - c[i];
            a = a + dd * dd;
            b = b + dd * p;
            k = k + p * p;
        end
        rr = cfg_r;
        k = k - rr * rr;
        if (a == 0) return w;
        disc = b * b - a * k;
        if (disc < 0) return w;
        s = $signed(isqrt(disc <<< 32));
        mb = -(b <<< 16);
        if (mb - s >= 0) num = mb - s;
        else if (mb + s >= 0) num = mb + s;
        else return w;
        q = num / a;
        tt = (q > 256'sh7fffffff) ? 64'sh7fffffff : 64'(q);
        for (int i = 0; i < 3; i++)
        begin
            pt = 64'(o[i]) + ((64'(d[i]) * tt) >>> 16);
            if (pt > 64'sh7fffffff) pt = 64'sh7fffffff;
            if (pt < -64'sh80000000) pt = -64'sh80000000;
            pv[i] = pt[31:0];
            qv = pt - c[i];
            mag = qv < 0 ? -qv : qv;
            if (cfg_r == 0) m = 0;
            else
            begin
                m = (mag * 65536 + cfg_r / 2) / cfg_r;
                if (m > 65536) m = 65536;
            end
            nv[i] = qv < 0 ? 18'(-m) : 18'(m);
        end
        w.hit = 1'b1;
        w.tdist = tt[30:0];
        w.px = pv[0]; w.py = pv[1]; w.pz = pv[2];
        w.nx = nv[0]; w.ny = nv[1]; w.nz = nv[2];
        return w;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", field, got, want, $time);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (hits_pending.size() == 0)
            begin
                report_mismatch("unexpected word", {31'd0, hit}, 32'd0);
            end
            else
            begin
                hit_word_t e;
                e = hits_pending.pop_front();
                if (hit !== e.hit) report_mismatch("hit", hit, e.hit);
                if (hit_distance !== e.tdist)
                    report_mismatch("hit_distance", hit_distance, e.tdist);
                if (point_x !== e.px) report_mismatch("point_x", point_x, e.px);
                if (point_y !== e.py) report_mismatch("point_y", point_y, e.py);
                if (point_z !== e.pz) report_mismatch("point_z", point_z, e.pz);
                if (normal_x !== e.nx) report_mismatch("normal_x", normal_x, e.nx);
                if (normal_y !== e.ny) report_mismatch("normal_y", normal_y, e.ny);
                if (normal_z !== e.nz) report_mismatch("normal_z", normal_z, e.nz);
                if (object_id !== e.id) report_mismatch("object_id", object_id, e.id);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((ray_valid && !ray_stall) || (result_valid && !result_stall) || psel)
            quiet_cnt <= 0;
        else
            quiet_cnt <= quiet_cnt + 1;
        if (quiet_cnt >= STALL_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic reg_write(input rsi_reg_e idx, input logic [31:0] val);
        @(negedge clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= 5'(idx) << 2; pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic drain();
        wait (hits_pending.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_sphere(input logic [31:0] cx, cy, cz, input logic [30:0] r,
                              input logic [15:0] id);
        drain();
        reg_write(RSI_REG_CENTER_X, cx);
        reg_write(RSI_REG_CENTER_Y, cy);
        reg_write(RSI_REG_CENTER_Z, cz);
        reg_write(RSI_REG_RADIUS, {1'b0, r});
        reg_write(RSI_REG_ID, {16'd0, id});
        sph_cx = cx; sph_cy = cy; sph_cz = cz; sph_r = r; sph_id = id;
    endtask

    task automatic send_ray(input logic [31:0] ox, oy, oz, dx, dy, dz);
        logic signed [31:0] o[3], d[3];
        @(negedge clk);
        while (!idle_free && $urandom_range(99) < 23)
        begin
            ray_valid <= 1'b0;
            @(negedge clk);
        end
        ray_valid <= 1'b1;
        ray_origin_x <= ox; ray_origin_y <= oy; ray_origin_z <= oz;
        ray_dir_x <= dx; ray_dir_y <= dy; ray_dir_z <= dz;
        do @(posedge clk); while (ray_stall);
        o[0] = ox; o[1] = oy; o[2] = oz;
        d[0] = dx; d[1] = dy; d[2] = dz;
        hits_pending.push_back(trace_ray(o, d));
    endtask

    task automatic end_burst();
        @(negedge clk);
        ray_valid <= 1'b0;
    endtask

    task automatic test_unit_sphere();
        send_ray(0, 0, -32'sd327680, 0, 0, 32'sd65536);
        send_ray(0, 0, 0, 32'sd65536, 0, 0);
        send_ray(0, 0, 32'sd327680, 0, 0, 32'sd65536);
        send_ray(32'sd65536, 0, -32'sd327680, 0, 0, 32'sd65536);
        send_ray(32'sd70000, 0, -32'sd327680, 0, 0, 32'sd65536);
        send_ray(0, 0, 0, 0, 0, 0);
        send_ray(0, 0, -32'sd327680, 0, 0, 1);
        send_ray(0, -32'sd65536, 0, 0, 32'sd65536, 0);
        send_ray(32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
                 32'h7fffffff);
        send_ray(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
                 32'h80000000);
        send_ray(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
                 32'hffffffff);
        send_ray(0, 0, 32'h80000000, 0, 0, 32'h7fffffff);
        send_ray(10, -20, 30, 32'h80000000, 1, -1);
        send_ray(0, 0, -32'sd131072, 32'sd3, 32'sd5, 32'sd65536);
        end_burst();
    endtask

    task automatic test_point_sphere();
        set_sphere(32'sd65536, 32'sd131072, -32'sd65536, 31'd0, 16'hffff);
        send_ray(32'sd65536, 32'sd131072, -32'sd327680, 0, 0, 32'sd65536);
        send_ray(0, 0, 0, 32'sd65536, 32'sd131072, -32'sd65536);
        send_ray(0, 0, 0, 0, 32'sd65536, 0);
        end_burst();
    endtask

    task automatic test_extreme_spheres();
        set_sphere(32'h7fffffff, 32'h80000000, 32'h7fffffff, 31'h7fffffff, 16'h5a5a);
        send_ray(0, 0, 0, 32'sd65536, 0, 0);
        send_ray(32'h80000000, 32'h7fffffff, 0, 32'sd65536, -32'sd65536, 1);
        send_ray(32'h7fffffff, 32'h80000000, 32'h7fffffff, 0, 0, 32'sd65536);
        end_burst();
        set_sphere(32'h80000000, 32'h80000000, 32'h80000000, 31'd1, 16'd1);
        send_ray(32'h80000000, 32'h80000000, 32'h80000000, 1, 0, 0);
        send_ray(32'h80000000, 32'h80000000, 32'h80000100, 0, 0, -1);
        end_burst();
    endtask

    task automatic random_batch(input int count);
        logic signed [31:0] off[3], o[3], d[3];
        int sh, mode;
        for (int n = 0; n < count; n++)
        begin
            mode = $urandom_range(99);
            sh = $urandom_range(4, 26);
            for (int i = 0; i < 3; i++)
                off[i] = $signed($urandom) >>> (31 - sh);
            o[0] = sph_cx + off[0]; o[1] = sph_cy + off[1]; o[2] = sph_cz + off[2];
            for (int i = 0; i < 3; i++)
            begin
                if (mode < 55)
                    d[i] = -off[i] + ($signed($urandom) >>> (31 - sh + 3));
                else if (mode < 75)
                    d[i] = $signed($urandom) >>> $urandom_range(0, 20);
                else
                begin
                    o[i] = $urandom;
                    d[i] = $urandom;
                end
            end
            if (mode >= 55 && mode < 75)
                for (int i = 0; i < 3; i++)
                    o[i] = (sph_cx + sph_cy + sph_cz) / 3 * 0 + o[i];
            send_ray(o[0], o[1], o[2], d[0], d[1], d[2]);
        end
        end_burst();
    endtask

    task automatic test_random_spheres();
        logic [30:0] r;
        for (int ph = 0; ph < 6; ph++)
        begin
            r = (ph == 5) ? 31'($urandom) : 31'($urandom_range(1, 1 << 24));
            set_sphere($signed($urandom) >>> $urandom_range(4, 12),
                       $signed($urandom) >>> $urandom_range(4, 12),
                       $signed($urandom) >>> $urandom_range(4, 12), r, 16'($urandom));
            if (ph == 2) idle_free = 1;
            random_batch(95);
            idle_free = 0;
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_unit_sphere();
        test_point_sphere();
        test_extreme_spheres();
        test_random_spheres();
        drain();
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> files.f
src/rsi_pkg.sv
src/rsi_mul.sv
src/rsi_front.sv
src/rsi_fifo.sv
src/rsi_back.sv
src/ray_sphere_intersect_core.sv
src/rsi_chk.sv
bench/ray_sphere_intersect_core_tb.sv
